@@ rtl/core/emh_pkg.sv @@
// Package: shared types, codes and defaults of the event multiplicity histogram.
`timescale 1ns / 1ps
package emh_pkg;

  localparam int NUM_BINS_DEF    = 1024;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int VALUE_WIDTH     = 10;
  localparam int ACC_WIDTH       = 16;

  localparam logic [9:0] TOP_VALUE_RESET = 10'd1023;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ACC_OVF   = 2'd1;
  localparam logic [1:0] STATUS_ABOVE_TOP = 2'd2;
  localparam logic [1:0] STATUS_TOTAL_OVF = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] amount;
    logic [9:0] read_bin;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] current_value;
    logic [31:0] bin_count;
    logic [31:0] total_events;
    logic [31:0] largest_count;
    logic [9:0]  largest_value;
  } result_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic clear_done;
  } dp_stat_t;

endpackage

@@ rtl/core/emh_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module emh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/emh_ctrl.sv @@
// Controller: clearing pass, request acceptance and result handoff.
`timescale 1ns / 1ps
module emh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  emh_pkg::dp_stat_t stat,
  output emh_pkg::ctl_t     ctl
);
  import emh_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    ctl.clear_en = 1'b0;
    ctl.accept   = 1'b0;
    ctl.finish   = 1'b0;
    item_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        ctl.clear_en = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          ctl.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!result_valid || !result_stall) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> result_valid)
    else $error("result not presented after finish");

  a_rise_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_EXEC)
    else $error("result appeared without an executed request");

  a_clear_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && stat.clear_done) |=> state == ST_IDLE)
    else $error("clearing pass did not end in idle");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |=> state == ST_EXEC)
    else $error("accepted request not executed");

endmodule

@@ rtl/core/emh_dp.sv @@
// Datapath: accumulator, totals, peaks, bin memory and result register.
`timescale 1ns / 1ps
module emh_dp #(
  parameter int NUM_BINS    = emh_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = emh_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  emh_pkg::ctl_t     ctl,
  output emh_pkg::dp_stat_t stat,
  input  emh_pkg::item_t    item,
  output emh_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [9:0]        cfg_data
);
  import emh_pkg::*;

  localparam int AW = $clog2(NUM_BINS);
  localparam int CW = COUNT_WIDTH;

  item_t                 item_q;
  logic [ACC_WIDTH-1:0]  accumulator;
  logic [CW-1:0]         event_total;
  logic [CW-1:0]         peak_count;
  logic [9:0]            peak_value;
  logic [9:0]            top_value;
  logic [AW-1:0]         clear_cnt;

  logic [ACC_WIDTH-1:0]  accumulator_next;
  logic [CW-1:0]         event_total_next;
  logic [CW-1:0]         peak_count_next;
  logic [9:0]            peak_value_next;
  result_t               result_next;

  logic [31:0]           acc_ext;
  logic [31:0]           rb_in_ext;
  logic [31:0]           rb_q_ext;
  logic [AW-1:0]         acc_addr;
  logic [AW-1:0]         raddr;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [CW-1:0]         ram_wdata;
  logic [CW-1:0]         rdata;
  logic [CW-1:0]         inc;
  logic [ACC_WIDTH:0]    sum;
  logic                  above_top;
  logic                  close_ok;
  logic [CW-1:0]         count;
  logic [63:0]           count_ext;
  logic [63:0]           total_ext;
  logic [63:0]           peak_ext;

  assign acc_ext   = 32'(accumulator);
  assign rb_in_ext = 32'(item.read_bin);
  assign rb_q_ext  = 32'(item_q.read_bin);
  assign acc_addr  = acc_ext[AW-1:0];
  assign raddr     = (item.cmd == CMD_CLOSE) ? acc_addr : rb_in_ext[AW-1:0];

  assign stat.clear_done = (clear_cnt == AW'(NUM_BINS - 1));

  assign inc       = rdata + CW'(1);
  assign sum       = {1'b0, accumulator} + (ACC_WIDTH + 1)'(item_q.amount);
  assign above_top = (accumulator > {6'd0, top_value}) || (acc_ext >= 32'(NUM_BINS));
  assign close_ok  = (item_q.cmd == CMD_CLOSE) && !above_top && !(&event_total);

  assign ram_we    = ctl.clear_en || (ctl.finish && close_ok);
  assign ram_waddr = ctl.clear_en ? clear_cnt : acc_addr;
  assign ram_wdata = ctl.clear_en ? '0 : inc;

  emh_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    accumulator_next = accumulator;
    event_total_next = event_total;
    peak_count_next  = peak_count;
    peak_value_next  = peak_value;
    count            = '0;
    result_next      = '0;
    case (item_q.cmd)
      CMD_ADD: begin
        if (sum[ACC_WIDTH]) begin
          result_next.status = STATUS_ACC_OVF;
        end else begin
          accumulator_next = sum[ACC_WIDTH-1:0];
        end
      end
      CMD_CLOSE: begin
        if (above_top) begin
          result_next.status = STATUS_ABOVE_TOP;
        end else if (&event_total) begin
          result_next.status = STATUS_TOTAL_OVF;
        end else begin
          count            = inc;
          event_total_next = event_total + CW'(1);
          accumulator_next = '0;
          if (inc > peak_count) begin
            peak_count_next = inc;
          end
          if (accumulator > {6'd0, peak_value}) begin
            peak_value_next = accumulator[9:0];
          end
        end
      end
      CMD_READ: begin
        if (rb_q_ext < 32'(NUM_BINS)) begin
          count = rdata;
        end
      end
      default: begin
        count = '0;
      end
    endcase
    count_ext = 64'(count);
    total_ext = 64'(event_total_next);
    peak_ext  = 64'(peak_count_next);
    result_next.current_value = accumulator_next;
    result_next.bin_count     = count_ext[31:0];
    result_next.total_events  = total_ext[31:0];
    result_next.largest_count = peak_ext[31:0];
    result_next.largest_value = peak_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      event_total <= '0;
      peak_count  <= '0;
      peak_value  <= '0;
      top_value   <= TOP_VALUE_RESET;
      clear_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        top_value <= cfg_data;
      end
      if (ctl.clear_en && !stat.clear_done) begin
        clear_cnt <= clear_cnt + AW'(1);
      end
      if (ctl.finish) begin
        accumulator <= accumulator_next;
        event_total <= event_total_next;
        peak_count  <= peak_count_next;
        peak_value  <= peak_value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_q <= item;
    end
    if (ctl.finish) begin
      result <= result_next;
    end
  end

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    (ctl.finish && close_ok) |=> event_total == $past(event_total) + CW'(1))
    else $error("event total not advanced on a binned close");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (ctl.finish && close_ok) |=> accumulator == '0)
    else $error("accumulator not cleared on a binned close");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ctl.clear_en || ctl.finish))
    else $error("bin memory written outside clear or finish");

endmodule

@@ rtl/core/event_multiplicity_histogram.sv @@
// Flow: a request is accepted in the idle state and executed in the exec state, where its
// result is registered once the output is free. A new request is taken only after the
// previous one has finished, as the registered read of the bin memory is followed by its
// write-back. A waiting result does not block acceptance of the next request, which
// finishes only once that result is taken. Reset: synchronous; the bin memory is then
// cleared one entry a cycle, during which no request is taken. top_value resets to 1023.
`timescale 1ns / 1ps
module event_multiplicity_histogram #(
  parameter int NUM_BINS    = emh_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = emh_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  emh_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output emh_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [9:0]       cfg_data
);
  import emh_pkg::*;

  ctl_t     ctl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  emh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .ctl          (ctl)
  );

  emh_dp #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .stat     (stat),
    .item     (item),
    .result   (result),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data)
  );

endmodule
